/* rtl/gsedf_pkg.sv */
// gsedf_pkg: shared types and constants for the gse frame deframer
// parse phases, byte classes, register indexes, queue entry and result records
// no dependencies
package gsedf_pkg;

  typedef enum logic [2:0] {
    PH_FRAME_HDR = 3'd0,
    PH_PKT_LOW   = 3'd1,
    PH_PKT_HIGH  = 3'd2,
    PH_EXT       = 3'd3,
    PH_PAYLOAD   = 3'd4,
    PH_ALIGN     = 3'd5,
    PH_FRAME_PAD = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    CLS_FRAME_HDR = 3'd0,
    CLS_PKT_HDR   = 3'd1,
    CLS_EXT_HDR   = 3'd2,
    CLS_PAYLOAD   = 3'd3,
    CLS_ALIGN_PAD = 3'd4,
    CLS_FRAME_PAD = 3'd5,
    CLS_CLEAR_ACK = 3'd6
  } byte_class_e;

  typedef enum logic [1:0] {
    REG_FORWARD_ENABLE = 2'd0,
    REG_FRAME_HDR      = 2'd1,
    REG_START_EXTRA    = 2'd2
  } reg_idx_e;

  // statistics counter slots
  localparam int unsigned NUM_CNT     = 5;
  localparam int unsigned CNT_PACKET  = 0;
  localparam int unsigned CNT_FRAME   = 1;
  localparam int unsigned CNT_PAYLOAD = 2;
  localparam int unsigned CNT_HEADER  = 3;
  localparam int unsigned CNT_PADDING = 4;

  // flags byte of a packet header
  localparam logic [7:0] FLAG_START  = 8'b0001_0000;
  localparam logic [7:0] FLAG_END    = 8'b0000_1000;
  localparam logic [2:0] LEN_HI_MASK = 3'b111;

  localparam logic [7:0] FRAME_HDR_RESET   = 8'd10;
  localparam logic [3:0] START_EXTRA_RESET = 4'd4;

  // front to back queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    byte_class_e cls;
    logic        dual;
    logic        fwd;
    logic        plast;
    logic        fstart;
    logic        fend;
    logic        frame_end;
  } entry_t;

  typedef struct packed {
    logic [31:0] padding_total;
    logic [31:0] header_total;
    logic [31:0] payload_total;
    logic [31:0] frame_count;
    logic [31:0] packet_count;
    logic        run_last;
    logic        fragment_end;
    logic        fragment_start;
    logic        payload_last;
    logic        forward_valid;
    byte_class_e byte_class;
    logic [7:0]  out_byte;
  } result_t;

  // phase after a byte of a packet is done
  function automatic phase_e next_phase(logic [3:0] extra, logic [10:0] len, logic pad);
    phase_e ph;
    if (extra != 4'd0) begin
      ph = PH_EXT;
    end else if (len != 11'd0) begin
      ph = PH_PAYLOAD;
    end else if (pad) begin
      ph = PH_ALIGN;
    end else begin
      ph = PH_PKT_LOW;
    end
    return ph;
  endfunction

endpackage

/* rtl/gse_frame_deframer_core.sv */
// gse_frame_deframer_core: top level of the gse frame deframer
// apb register file, front parser, record queue and back emitter; uses gsedf_pkg
//
// Takes one baseband-frame byte per beat and returns classified bytes with running
// statistics. The input side accepts a byte every clock while the queue has room: the
// front parser classifies it in the cycle it arrives and writes a record into a
// four-entry queue, and the back end turns each record into output beats through a
// registered output stage, so a stalled output does not stop input until the queue
// fills. A packet header's low byte yields no beat and its flags byte yields two,
// which the back end sends as successive beats; the queue absorbs that, keeping the
// sustained rate at one byte per clock while the output is not stalled. With the queue
// empty, a byte's first output beat passes through the queue and then the output stage.
// Counters are COUNTER_WIDTH bits wide, wrap, and are reported as their low 32 bits.
module gse_frame_deframer_core #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // frame_end
  input  logic [0:0]   s_axis_tuser,   // [0] kind
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] out_byte, [8] forward_valid, [9] payload_last, [10] fragment_start,
  // [11] fragment_end, [43:12] packet_count, [75:44] frame_count,
  // [107:76] payload_total, [139:108] header_total, [171:140] padding_total
  output logic [175:0] m_axis_tdata,
  output logic         m_axis_tlast,   // run_last
  output logic [2:0]   m_axis_tuser,   // [2:0] byte_class
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import gsedf_pkg::*;

  logic       forward_enable_q;
  logic [7:0] frame_header_bytes_q;
  logic [3:0] start_extra_bytes_q;
  logic       cfg_write;
  reg_idx_e   reg_idx;

  entry_t     push_entry, head_entry;
  logic       q_push, q_ready, q_valid, q_pop;
  result_t    res;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forward_enable_q     <= 1'b0;
      frame_header_bytes_q <= FRAME_HDR_RESET;
      start_extra_bytes_q  <= START_EXTRA_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_FORWARD_ENABLE: forward_enable_q     <= pwdata[0];
        REG_FRAME_HDR:      frame_header_bytes_q <= pwdata[7:0];
        REG_START_EXTRA:    start_extra_bytes_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FORWARD_ENABLE: prdata = {31'd0, forward_enable_q};
      REG_FRAME_HDR:      prdata = {24'd0, frame_header_bytes_q};
      REG_START_EXTRA:    prdata = {28'd0, start_extra_bytes_q};
      default:            prdata = 32'd0;
    endcase
  end

  gsedf_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (s_axis_tvalid),
    .in_ready_o           (s_axis_tready),
    .kind_i               (s_axis_tuser[0]),
    .data_byte_i          (s_axis_tdata),
    .frame_end_i          (s_axis_tlast),
    .forward_enable_i     (forward_enable_q),
    .frame_header_bytes_i (frame_header_bytes_q),
    .start_extra_bytes_i  (start_extra_bytes_q),
    .q_ready_i            (q_ready),
    .q_push_o             (q_push),
    .q_entry_o            (push_entry)
  );

  gsedf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .entry_o (head_entry),
    .pop_i   (q_pop)
  );

  gsedf_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (head_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {4'd0, res.padding_total, res.header_total, res.payload_total,
                         res.frame_count, res.packet_count, res.fragment_end,
                         res.fragment_start, res.payload_last, res.forward_valid,
                         res.out_byte};
  assign m_axis_tlast = res.run_last;
  assign m_axis_tuser = res.byte_class;

endmodule

/* rtl/gsedf_front.sv */
// gsedf_front: accepts frame bytes, runs the packet parser, classifies bytes
// pushes one record per byte that gives results into the queue; uses gsedf_pkg
module gsedf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [7:0]        data_byte_i,
  input  logic              frame_end_i,
  input  logic              forward_enable_i,
  input  logic [7:0]        frame_header_bytes_i,
  input  logic [3:0]        start_extra_bytes_i,
  input  logic              q_ready_i,
  output logic              q_push_o,
  output gsedf_pkg::entry_t q_entry_o
);
  import gsedf_pkg::*;

  phase_e      phase_q, phase_d, eff_phase;
  logic [7:0]  skip_q, skip_d;
  logic [7:0]  held_q, held_d;
  logic [10:0] len_q, len_d;
  logic [3:0]  extra_q, extra_d;
  logic        pad_q, pad_d;
  logic [1:0]  flags_q, flags_d;

  logic        accept;
  logic        zero_hdr;
  logic        start_w, end_w;
  logic [10:0] len_w;
  logic [3:0]  ext_w;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;

  assign eff_phase = (phase_q == PH_FRAME_HDR && skip_q == 8'd0) ? PH_PKT_LOW : phase_q;

  assign zero_hdr = (held_q == 8'd0) && (data_byte_i == 8'd0);
  assign start_w  = |(data_byte_i & FLAG_START);
  assign end_w    = |(data_byte_i & FLAG_END);
  assign len_w    = {data_byte_i[2:0] & LEN_HI_MASK, held_q};
  // extension bytes never run past the packet length
  assign ext_w    = !start_w ? 4'd0 :
                    ({7'd0, start_extra_bytes_i} > len_w) ? len_w[3:0] : start_extra_bytes_i;

  // next state
  always_comb begin
    phase_d = phase_q;
    skip_d  = skip_q;
    held_d  = held_q;
    len_d   = len_q;
    extra_d = extra_q;
    pad_d   = pad_q;
    flags_d = flags_q;
    if (accept && !kind_i) begin
      case (eff_phase)
        PH_FRAME_HDR: begin
          skip_d = skip_q - 8'd1;
          if (skip_d == 8'd0) begin
            phase_d = PH_PKT_LOW;
          end
        end
        PH_PKT_LOW: begin
          if (frame_end_i) begin
            flags_d = 2'b00;
          end else begin
            held_d  = data_byte_i;
            phase_d = PH_PKT_HIGH;
          end
        end
        PH_PKT_HIGH: begin
          if (zero_hdr) begin
            flags_d = 2'b00;
            phase_d = PH_FRAME_PAD;
          end else begin
            flags_d = {start_w, end_w};
            extra_d = ext_w;
            len_d   = len_w - {7'd0, ext_w};
            pad_d   = len_w[0];
            phase_d = next_phase(ext_w, len_d, len_w[0]);
          end
        end
        PH_EXT: begin
          extra_d = extra_q - 4'd1;
          phase_d = next_phase(extra_d, len_q, pad_q);
        end
        PH_PAYLOAD: begin
          len_d   = len_q - 11'd1;
          phase_d = next_phase(extra_q, len_d, pad_q);
        end
        PH_ALIGN: begin
          pad_d   = 1'b0;
          phase_d = next_phase(extra_q, len_q, 1'b0);
        end
        default: begin
          phase_d = PH_FRAME_PAD;
        end
      endcase
      // frame end drops any open packet and rearms the header skip
      if (frame_end_i) begin
        phase_d = PH_FRAME_HDR;
        skip_d  = frame_header_bytes_i;
        held_d  = 8'd0;
        len_d   = 11'd0;
        extra_d = 4'd0;
        pad_d   = 1'b0;
        flags_d = 2'b00;
      end
    end
  end

  // queue record
  always_comb begin
    q_push_o  = 1'b0;
    q_entry_o = '0;
    if (accept) begin
      if (kind_i) begin
        q_push_o      = 1'b1;
        q_entry_o.cls = CLS_CLEAR_ACK;
      end else begin
        q_entry_o.frame_end  = frame_end_i;
        q_entry_o.first_byte = data_byte_i;
        case (eff_phase)
          PH_FRAME_HDR: begin
            q_push_o      = 1'b1;
            q_entry_o.cls = CLS_FRAME_HDR;
          end
          PH_PKT_LOW: begin
            // lone trailing byte is frame padding
            q_push_o      = frame_end_i;
            q_entry_o.cls = CLS_FRAME_PAD;
          end
          PH_PKT_HIGH: begin
            q_push_o              = 1'b1;
            q_entry_o.dual        = 1'b1;
            q_entry_o.first_byte  = held_q;
            q_entry_o.second_byte = data_byte_i;
            if (zero_hdr) begin
              q_entry_o.cls = CLS_FRAME_PAD;
            end else begin
              q_entry_o.cls    = CLS_PKT_HDR;
              q_entry_o.fstart = start_w;
              q_entry_o.fend   = end_w;
            end
          end
          PH_EXT: begin
            q_push_o         = 1'b1;
            q_entry_o.cls    = CLS_EXT_HDR;
            q_entry_o.fstart = flags_q[1];
            q_entry_o.fend   = flags_q[0];
          end
          PH_PAYLOAD: begin
            q_push_o         = 1'b1;
            q_entry_o.cls    = CLS_PAYLOAD;
            q_entry_o.fwd    = forward_enable_i;
            q_entry_o.plast  = (len_q == 11'd1);
            q_entry_o.fstart = flags_q[1];
            q_entry_o.fend   = flags_q[0];
          end
          PH_ALIGN: begin
            q_push_o         = 1'b1;
            q_entry_o.cls    = CLS_ALIGN_PAD;
            q_entry_o.fstart = flags_q[1];
            q_entry_o.fend   = flags_q[0];
          end
          default: begin
            q_push_o      = 1'b1;
            q_entry_o.cls = CLS_FRAME_PAD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FRAME_HDR;
      skip_q  <= FRAME_HDR_RESET;
      held_q  <= 8'd0;
      len_q   <= 11'd0;
      extra_q <= 4'd0;
      pad_q   <= 1'b0;
      flags_q <= 2'b00;
    end else begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      held_q  <= held_d;
      len_q   <= len_d;
      extra_q <= extra_d;
      pad_q   <= pad_d;
      flags_q <= flags_d;
    end
  end

endmodule

/* rtl/gsedf_queue.sv */
// gsedf_queue: short fifo of classified records between front and back
// depth from gsedf_pkg::QDEPTH; uses gsedf_pkg
module gsedf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gsedf_pkg::entry_t entry_i,
  output logic              ready_o,
  output logic              valid_o,
  output gsedf_pkg::entry_t entry_o,
  input  logic              pop_i
);
  import gsedf_pkg::*;

  entry_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wptr_q, rptr_q;
  logic [QPTR_W:0]    cnt_q;

  assign ready_o = (cnt_q != (QPTR_W+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  qdepth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= (QPTR_W+1)'(QDEPTH)))
    else $error("queue fill count beyond depth");

  no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ready_o |-> !push_i))
    else $error("push into full queue");

  no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!valid_o |-> !pop_i))
    else $error("pop from empty queue");

endmodule

/* rtl/gsedf_back.sv */
// gsedf_back: drains queue records into output beats and keeps the statistics counters
// two-byte header records leave as two beats; uses gsedf_pkg
module gsedf_back #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  gsedf_pkg::entry_t  q_entry_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gsedf_pkg::result_t out_res_o
);
  import gsedf_pkg::*;

  logic [COUNTER_WIDTH-1:0] cnt_q [NUM_CNT];
  logic [COUNTER_WIDTH-1:0] cnt_d [NUM_CNT];
  logic                     sel_q;
  logic                     out_valid_q;
  result_t                  res_q;
  logic                     take;
  logic                     last;

  assign take        = q_valid_i && (!out_valid_q || out_ready_i);
  assign last        = !q_entry_i.dual || sel_q;
  assign q_pop_o     = take && last;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  // counters after this beat is counted
  always_comb begin
    for (int i = 0; i < NUM_CNT; i++) begin
      cnt_d[i] = cnt_q[i];
    end
    if (take) begin
      case (q_entry_i.cls)
        CLS_PKT_HDR: begin
          cnt_d[CNT_HEADER] = cnt_q[CNT_HEADER] + COUNTER_WIDTH'(1);
          if (!sel_q) begin
            cnt_d[CNT_PACKET] = cnt_q[CNT_PACKET] + COUNTER_WIDTH'(1);
          end
        end
        CLS_EXT_HDR: cnt_d[CNT_HEADER] = cnt_q[CNT_HEADER] + COUNTER_WIDTH'(1);
        CLS_PAYLOAD: cnt_d[CNT_PAYLOAD] = cnt_q[CNT_PAYLOAD] + COUNTER_WIDTH'(1);
        CLS_ALIGN_PAD, CLS_FRAME_PAD: begin
          cnt_d[CNT_PADDING] = cnt_q[CNT_PADDING] + COUNTER_WIDTH'(1);
        end
        CLS_CLEAR_ACK: begin
          for (int i = 0; i < NUM_CNT; i++) begin
            cnt_d[i] = '0;
          end
        end
        default: ;
      endcase
      if (last && q_entry_i.frame_end) begin
        cnt_d[CNT_FRAME] = cnt_q[CNT_FRAME] + COUNTER_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_q[i] <= '0;
      end
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
      if (take) begin
        sel_q       <= !last;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q.out_byte       <= sel_q ? q_entry_i.second_byte : q_entry_i.first_byte;
      res_q.byte_class     <= q_entry_i.cls;
      res_q.forward_valid  <= q_entry_i.fwd;
      res_q.payload_last   <= q_entry_i.plast;
      res_q.fragment_start <= q_entry_i.fstart;
      res_q.fragment_end   <= q_entry_i.fend;
      res_q.run_last       <= last;
      res_q.packet_count   <= 32'(cnt_d[CNT_PACKET]);
      res_q.frame_count    <= 32'(cnt_d[CNT_FRAME]);
      res_q.payload_total  <= 32'(cnt_d[CNT_PAYLOAD]);
      res_q.header_total   <= 32'(cnt_d[CNT_HEADER]);
      res_q.padding_total  <= 32'(cnt_d[CNT_PADDING]);
    end
  end

  second_beat_has_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_q |-> (q_valid_i && q_entry_i.dual)))
    else $error("second header beat without a two-byte record");

  clear_zeroes_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((take && q_entry_i.cls == CLS_CLEAR_ACK) |=>
      (cnt_q[CNT_PACKET] == '0 && cnt_q[CNT_FRAME] == '0 && cnt_q[CNT_PAYLOAD] == '0 &&
       cnt_q[CNT_HEADER] == '0 && cnt_q[CNT_PADDING] == '0)))
    else $error("counters not cleared after clear ack");

  split_only_headers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((out_valid_q && !res_q.run_last) |->
      (res_q.byte_class == CLS_PKT_HDR || res_q.byte_class == CLS_FRAME_PAD)))
    else $error("non-final beat of an unexpected class");

endmodule
